// ===== rtl/assert_macros.svh =====
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");

// condition that holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

`endif

// ===== rtl/bst_pkg.sv =====
// types and constants of the byte stream tokenizer
`default_nettype none
package bst_pkg;

  localparam int PosW = 20;

  // token kinds
  localparam logic [5:0] K_UNKNOWN = 6'd0;
  localparam logic [5:0] K_EOF     = 6'd1;
  localparam logic [5:0] K_ASSIGN  = 6'd2;
  localparam logic [5:0] K_EQ      = 6'd3;
  localparam logic [5:0] K_NE      = 6'd4;
  localparam logic [5:0] K_LT      = 6'd5;
  localparam logic [5:0] K_SHL     = 6'd6;
  localparam logic [5:0] K_LE      = 6'd7;
  localparam logic [5:0] K_GT      = 6'd8;
  localparam logic [5:0] K_SHR     = 6'd9;
  localparam logic [5:0] K_GE      = 6'd10;
  localparam logic [5:0] K_LBRACK  = 6'd11;
  localparam logic [5:0] K_RBRACK  = 6'd12;
  localparam logic [5:0] K_LBRACE  = 6'd13;
  localparam logic [5:0] K_RBRACE  = 6'd14;
  localparam logic [5:0] K_LPAREN  = 6'd15;
  localparam logic [5:0] K_RPAREN  = 6'd16;
  localparam logic [5:0] K_SEMI    = 6'd17;
  localparam logic [5:0] K_PLUS    = 6'd18;
  localparam logic [5:0] K_MINUS   = 6'd19;
  localparam logic [5:0] K_STAR    = 6'd20;
  localparam logic [5:0] K_SLASH   = 6'd21;
  localparam logic [5:0] K_CARET   = 6'd22;
  localparam logic [5:0] K_FLOAT   = 6'd23;
  localparam logic [5:0] K_NUMBER  = 6'd24;
  localparam logic [5:0] K_STRING  = 6'd25;
  localparam logic [5:0] K_KW0     = 6'd26;
  localparam logic [5:0] K_IDENT   = 6'd38;

  // scanner modes
  localparam logic [3:0] M_IDLE = 4'd0;
  localparam logic [3:0] M_EQ   = 4'd1;
  localparam logic [3:0] M_BANG = 4'd2;
  localparam logic [3:0] M_LT   = 4'd3;
  localparam logic [3:0] M_GT   = 4'd4;
  localparam logic [3:0] M_INT  = 4'd5;
  localparam logic [3:0] M_FRAC = 4'd6;
  localparam logic [3:0] M_STR  = 4'd7;
  localparam logic [3:0] M_WORD = 4'd8;

  typedef struct packed {
    logic [5:0]  kind;
    logic [19:0] start;
    logic [19:0] len;
    logic [31:0] ival;
    logic [29:0] fval;
    logic [3:0]  fdig;
    logic        last;
  } token_t;

  // front to back transaction: up to two tokens from one byte
  typedef struct packed {
    logic   two;
    token_t t0;
    token_t t1;
  } slot_t;

  // keyword text packed one byte per char, low bytes hold the last char
  function automatic logic [63:0] kw_text(input logic [3:0] i);
    case (i)
      4'd0:  kw_text = 64'h6c6f6f70;
      4'd1:  kw_text = 64'h7072696e74;
      4'd2:  kw_text = 64'h6966;
      4'd3:  kw_text = 64'h656c6966;
      4'd4:  kw_text = 64'h656c7365;
      4'd5:  kw_text = 64'h696e74;
      4'd6:  kw_text = 64'h63686172;
      4'd7:  kw_text = 64'h626f6f6c;
      4'd8:  kw_text = 64'h73696e676c65;
      4'd9:  kw_text = 64'h646f75626c65;
      4'd10: kw_text = 64'h74727565;
      4'd11: kw_text = 64'h66616c7365;
      default: kw_text = 64'h0;
    endcase
  endfunction

  function automatic logic [3:0] kw_len(input logic [3:0] i);
    case (i)
      4'd0, 4'd3, 4'd4, 4'd6, 4'd7, 4'd10: kw_len = 4'd4;
      4'd1, 4'd11: kw_len = 4'd5;
      4'd2: kw_len = 4'd2;
      4'd5: kw_len = 4'd3;
      default: kw_len = 4'd6;
    endcase
  endfunction

endpackage
`default_nettype wire

// ===== rtl/bst_front.sv =====
// front part: scanner state machine that turns bytes into token transactions
`default_nettype none
module bst_front #(
  parameter int MaxSourceBytes = 1048576,
  parameter int KeywordChars = 6
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             take,
  input  wire logic [7:0]       source_byte,
  output bst_pkg::slot_t        slot,
  output logic                  slot_valid
);
  import bst_pkg::*;

  localparam int KbW = 8 * KeywordChars;
  localparam logic [19:0] LenMax = 20'hFFFFF;
  localparam logic [63:0] PosLast = 64'(MaxSourceBytes - 1);

  logic [3:0]     scan_mode, scan_mode_next;
  logic [19:0]    read_position, token_start, token_start_next;
  logic [31:0]    integer_accumulator, int_next;
  logic [29:0]    fraction_accumulator, frac_next;
  logic [3:0]     fraction_count, fcnt_next;
  logic [KbW-1:0] keyword_buffer, kb_next;
  logic [19:0]    word_length, wl_next;

  logic [7:0]  b;
  logic        dig, alp, spc, fresh;
  logic [31:0] digv;
  logic [19:0] pos_inc;
  logic        n0, n1;
  token_t      t0, t1, fr, wtok;
  logic        fr_v;
  logic [3:0]  fr_mode;
  logic [3:0]  kw_hit_idx;
  logic        kw_hit;

  assign b   = source_byte;
  assign dig = (b >= 8'h30) && (b <= 8'h39);
  assign alp = ((b >= 8'h61) && (b <= 8'h7a)) || ((b >= 8'h41) && (b <= 8'h5a));
  assign spc = (b == 8'h20) || ((b >= 8'd9) && (b <= 8'd13));
  assign digv = {28'd0, b[3:0]};

  // position advance with wrap
  always_comb begin
    if (64'(read_position) >= PosLast) pos_inc = '0;
    else pos_inc = read_position + 20'd1;
  end

  // keyword lookup against the held word
  always_comb begin
    kw_hit = 1'b0;
    kw_hit_idx = '0;
    for (int i = 0; i < 12; i++) begin
      if (!kw_hit && (word_length == {16'd0, kw_len(4'(i))}) &&
          (64'(keyword_buffer) == kw_text(4'(i)))) begin
        kw_hit = 1'b1;
        kw_hit_idx = 4'(i);
      end
    end
    wtok = '0;
    if (kw_hit && (word_length <= 20'(KeywordChars))) begin
      wtok.kind = K_KW0 + {2'd0, kw_hit_idx};
    end else begin
      wtok.kind = K_IDENT;
      wtok.start = token_start;
      wtok.len = word_length;
    end
  end

  // decode of a byte seen from idle
  always_comb begin
    fr = '0;
    fr_v = 1'b1;
    fr_mode = M_IDLE;
    unique case (b)
      8'h00: fr.kind = K_EOF;
      8'h3d: begin fr_v = 1'b0; fr_mode = M_EQ; end
      8'h21: begin fr_v = 1'b0; fr_mode = M_BANG; end
      8'h3c: begin fr_v = 1'b0; fr_mode = M_LT; end
      8'h3e: begin fr_v = 1'b0; fr_mode = M_GT; end
      8'h5b: fr.kind = K_LBRACK;
      8'h5d: fr.kind = K_RBRACK;
      8'h7b: fr.kind = K_LBRACE;
      8'h7d: fr.kind = K_RBRACE;
      8'h28: fr.kind = K_LPAREN;
      8'h29: fr.kind = K_RPAREN;
      8'h3b: fr.kind = K_SEMI;
      8'h2b: fr.kind = K_PLUS;
      8'h2d: fr.kind = K_MINUS;
      8'h2a: fr.kind = K_STAR;
      8'h2f: fr.kind = K_SLASH;
      8'h5e: fr.kind = K_CARET;
      8'h22: begin fr_v = 1'b0; fr_mode = M_STR; end
      default: begin
        if (spc) fr_v = 1'b0;
        else if (dig) begin fr_v = 1'b0; fr_mode = M_INT; end
        else if (alp) begin fr_v = 1'b0; fr_mode = M_WORD; end
        else fr.kind = K_UNKNOWN;
      end
    endcase
  end

  // scanner next state
  always_comb begin
    scan_mode_next = scan_mode;
    token_start_next = token_start;
    int_next = integer_accumulator;
    frac_next = fraction_accumulator;
    fcnt_next = fraction_count;
    kb_next = keyword_buffer;
    wl_next = word_length;
    n0 = 1'b0;
    t0 = '0;
    fresh = 1'b0;
    unique case (scan_mode)
      M_EQ: begin
        n0 = 1'b1;
        if (b == 8'h3d) begin t0.kind = K_EQ; scan_mode_next = M_IDLE; end
        else begin t0.kind = K_ASSIGN; fresh = 1'b1; end
      end
      M_BANG: begin
        n0 = 1'b1;
        if (b == 8'h3d) begin t0.kind = K_NE; scan_mode_next = M_IDLE; end
        else begin t0.kind = K_UNKNOWN; fresh = 1'b1; end
      end
      M_LT: begin
        n0 = 1'b1;
        if (b == 8'h3c) begin t0.kind = K_SHL; scan_mode_next = M_IDLE; end
        else if (b == 8'h3d) begin t0.kind = K_LE; scan_mode_next = M_IDLE; end
        else begin t0.kind = K_LT; fresh = 1'b1; end
      end
      M_GT: begin
        n0 = 1'b1;
        if (b == 8'h3e) begin t0.kind = K_SHR; scan_mode_next = M_IDLE; end
        else if (b == 8'h3d) begin t0.kind = K_GE; scan_mode_next = M_IDLE; end
        else begin t0.kind = K_GT; fresh = 1'b1; end
      end
      M_INT: begin
        if (dig) int_next = (integer_accumulator << 3) + (integer_accumulator << 1) + digv;
        else if (b == 8'h2e) begin
          scan_mode_next = M_FRAC;
          frac_next = '0;
          fcnt_next = '0;
        end else begin
          n0 = 1'b1;
          t0.kind = K_NUMBER;
          t0.ival = integer_accumulator;
          fresh = 1'b1;
        end
      end
      M_FRAC: begin
        if (dig) begin
          if (fraction_count < 4'd9) begin
            frac_next = (fraction_accumulator << 3) + (fraction_accumulator << 1) +
                        digv[29:0];
            fcnt_next = fraction_count + 4'd1;
          end
        end else begin
          n0 = 1'b1;
          t0.kind = K_FLOAT;
          t0.ival = integer_accumulator;
          t0.fval = fraction_accumulator;
          t0.fdig = fraction_count;
          fresh = 1'b1;
        end
      end
      M_STR: begin
        if (b == 8'h22) begin
          n0 = 1'b1;
          t0.kind = K_STRING; t0.start = token_start; t0.len = word_length;
          scan_mode_next = M_IDLE;
        end else if (b == 8'h00) begin
          n0 = 1'b1;
          t0.kind = K_STRING; t0.start = token_start; t0.len = word_length;
          fresh = 1'b1;
        end else if (word_length < LenMax) wl_next = word_length + 20'd1;
      end
      M_WORD: begin
        if (alp || dig || (b == 8'h5f)) begin
          if (word_length < 20'(KeywordChars)) kb_next = {keyword_buffer[KbW-9:0], b};
          if (word_length < LenMax) wl_next = word_length + 20'd1;
        end else begin
          n0 = 1'b1;
          t0 = wtok;
          fresh = 1'b1;
        end
      end
      default: fresh = 1'b1;
    endcase
    // byte handled again from idle
    if (fresh) begin
      scan_mode_next = fr_mode;
      if (fr_mode == M_STR) begin
        token_start_next = pos_inc;
        wl_next = '0;
      end else if (fr_mode == M_INT) begin
        int_next = digv;
      end else if (fr_mode == M_WORD) begin
        token_start_next = read_position;
        wl_next = 20'd1;
        kb_next = KbW'(b);
      end
    end
  end

  // pack up to two tokens into one transaction
  always_comb begin
    n1 = fresh && fr_v;
    t1 = fr;
    slot = '0;
    slot_valid = take && (n0 || n1);
    if (n0 && n1) begin
      slot.two = 1'b1;
      slot.t0 = t0;
      slot.t1 = t1;
      slot.t1.last = 1'b1;
    end else if (n0) begin
      slot.t0 = t0;
      slot.t0.last = 1'b1;
    end else begin
      slot.t0 = t1;
      slot.t0.last = 1'b1;
    end
  end

  // scanner registers
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode <= M_IDLE;
      read_position <= '0;
      token_start <= '0;
      integer_accumulator <= '0;
      fraction_accumulator <= '0;
      fraction_count <= '0;
      keyword_buffer <= '0;
      word_length <= '0;
    end else if (take) begin
      scan_mode <= scan_mode_next;
      token_start <= token_start_next;
      integer_accumulator <= int_next;
      fraction_accumulator <= frac_next;
      fraction_count <= fcnt_next;
      keyword_buffer <= kb_next;
      word_length <= wl_next;
      if (b != 8'h00) read_position <= pos_inc;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/bst_back.sv =====
// back part: queue of token pairs and the one-token-at-a-time output side
`default_nettype none
module bst_back #(
  parameter int QDepth = 4
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           wr,
  input  bst_pkg::slot_t      wr_slot,
  output logic                full,
  output logic                empty,
  input  wire logic           pop,
  output bst_pkg::token_t     head
);
  import bst_pkg::*;

  localparam int AW = $clog2(QDepth);

  slot_t        mem [QDepth];
  logic [AW-1:0] wp, rp;
  logic [AW:0]   count;
  logic          half;
  logic          rd_done;
  slot_t         cur;

  assign cur = mem[rp];
  assign empty = (count == '0);
  assign full = (count == (AW+1)'(QDepth));
  assign head = half ? cur.t1 : cur.t0;
  assign rd_done = pop && !empty && (half || !cur.two);

  // queue storage
  always_ff @(posedge clk) begin
    if (wr && !full) mem[wp] <= wr_slot;
  end

  // pointers and pair half select
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      count <= '0;
      half <= 1'b0;
    end else begin
      if (wr && !full) wp <= (wp == AW'(QDepth - 1)) ? '0 : wp + 1'b1;
      if (rd_done) rp <= (rp == AW'(QDepth - 1)) ? '0 : rp + 1'b1;
      count <= count + (AW+1)'(wr && !full) - (AW+1)'(rd_done);
      if (pop && !empty) half <= !rd_done;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/byte_stream_tokenizer_top.sv =====
// top level of the byte stream tokenizer
// One source byte is taken per cycle while full is low; the scanner state
// machine updates in that same cycle and hands at most two tokens as one
// transaction to a four-entry queue. Tokens leave one per cycle while pop is
// high and empty is low, so a byte that yields two tokens takes two pops;
// the result rate is set by the single output port, the input rate by the
// scanner update. No clearing pass is needed after reset.
`default_nettype none
`include "assert_macros.svh"
module byte_stream_tokenizer_top #(
  parameter int MaxSourceBytes = 1048576,
  parameter int KeywordChars = 6
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  source_byte,
  output logic             empty,
  input  wire logic        pop,
  output logic [5:0]       token_kind,
  output logic [19:0]      text_start,
  output logic [19:0]      text_length,
  output logic signed [31:0] int_value,
  output logic [29:0]      fraction_value,
  output logic [3:0]       fraction_digits,
  output logic             last_of_run
);
  import bst_pkg::*;

  slot_t  slot;
  logic   slot_valid;
  logic   take;
  token_t head;

  assign take = push && !full;

  bst_front #(.MaxSourceBytes(MaxSourceBytes), .KeywordChars(KeywordChars)) u_front (
    .clk, .rst, .take, .source_byte, .slot, .slot_valid
  );

  bst_back #(.QDepth(4)) u_back (
    .clk, .rst, .wr(slot_valid), .wr_slot(slot), .full, .empty, .pop, .head
  );

  assign token_kind = head.kind;
  assign text_start = head.start;
  assign text_length = head.len;
  assign int_value = signed'(head.ival);
  assign fraction_value = head.fval;
  assign fraction_digits = head.fdig;
  assign last_of_run = head.last;

  // checks
  `ASSERT_IMPL(a_eof_last, clk, rst, !empty && token_kind == K_EOF, last_of_run)
  `ASSERT_IMPL(a_fdig_range, clk, rst, !empty, fraction_digits <= 4'd9)
  `ASSERT_IMPL(a_float_only, clk, rst, !empty && token_kind != K_FLOAT,
               fraction_digits == 4'd0)
endmodule
`default_nettype wire
